/* sv/hbridge_motor_command_unit_defines.svh */
// Assertion macros for the H-bridge motor command unit.
// Included by the top level; expands to nothing when SYNTH is defined.
`ifndef HBRIDGE_MOTOR_COMMAND_UNIT_DEFINES_SVH
`define HBRIDGE_MOTOR_COMMAND_UNIT_DEFINES_SVH
`ifndef SYNTH
// Consequent checked in the same cycle as the antecedent
`define HMCU_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hbridge_motor_command_unit: same-cycle check failed");
// Consequent checked in the cycle after the antecedent
`define HMCU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hbridge_motor_command_unit: next-cycle check failed");
`else
`define HMCU_ASSERT_SAME(label, ante, cons)
`define HMCU_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* sv/hmcu_pkg.sv */
// Shared types, constants and the duty function of the H-bridge motor command unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hmcu_pkg;

  localparam int MOTORS_DEFAULT = 2;
  localparam int CMD_W          = 3;
  localparam int ARG_W          = 8;
  localparam int MOTOR_W        = 3;
  localparam int POWER_W        = 7;
  localparam int DUTY_W         = 8;

  localparam logic [ARG_W-1:0]   POWER_MAX  = 8'd100;
  localparam logic [DUTY_W-1:0]  DUTY_RESET = 8'd128;

  // power*255/100 as one multiply by 255*ceil(2^19/100), then a shift
  localparam int                 DUTY_SHIFT = 19;
  localparam int                 PROD_W     = 28;
  localparam logic [PROD_W-1:0]  DUTY_MUL   = 28'd1336965;

  typedef enum logic [CMD_W-1:0] {
    CMD_SELECT    = 3'd0,
    CMD_ON        = 3'd1,
    CMD_BRAKE     = 3'd2,
    CMD_DIRECTION = 3'd3,
    CMD_REVERSE   = 3'd4,
    CMD_POWER     = 3'd5
  } cmd_t;

  // Controller to datapath commands
  typedef struct packed {
    logic               load;   // capture the incoming command
    logic               step;   // process one motor and fill the output register
    logic [MOTOR_W-1:0] motor;  // motor handled by this step
  } dp_ctrl_t;

  function automatic logic [DUTY_W-1:0] duty_of(input logic [POWER_W-1:0] power);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(power) * DUTY_MUL;
    return DUTY_W'(prod >> DUTY_SHIFT);
  endfunction

endpackage

`default_nettype wire

/* sv/hmcu_ctrl.sv */
// Controller of the H-bridge motor command unit: command acceptance, motor
// sequencing and output valid. Depends on hmcu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hmcu_ctrl
  import hmcu_pkg::*;
#(
  parameter int MOTORS = MOTORS_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  output dp_ctrl_t dp_ctrl
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  localparam logic [MOTOR_W-1:0] LAST_MOTOR = MOTOR_W'(MOTORS - 1);

  state_t             state;
  logic [MOTOR_W-1:0] motor;
  logic               out_free;
  logic               step;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign step     = (state == S_RUN) && out_free;

  assign dp_ctrl.load  = s_tvalid && s_tready;
  assign dp_ctrl.step  = step;
  assign dp_ctrl.motor = motor;

  // Walk the motors one per free output slot, then return to idle
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      motor    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (step) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_RUN;
            motor <= '0;
          end
        end
        S_RUN: begin
          if (step) begin
            if (motor == LAST_MOTOR) begin
              state <= S_IDLE;
              motor <= '0;
            end else begin
              motor <= motor + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/hmcu_datapath.sv */
// Datapath of the H-bridge motor command unit: per-motor state, command
// update, pin and duty computation and the output register. Depends on hmcu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hmcu_datapath
  import hmcu_pkg::*;
#(
  parameter int MOTORS = MOTORS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_ctrl_t           dp_ctrl,
  input  logic [CMD_W-1:0]   cmd_in,
  input  logic [ARG_W-1:0]   arg_in,
  output logic [MOTOR_W-1:0] motor_index,
  output logic               pin_a,
  output logic               pin_b,
  output logic [DUTY_W-1:0]  duty,
  output logic               driven,
  output logic               last
);

  localparam int IW = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam logic [MOTOR_W-1:0] LAST_MOTOR = MOTOR_W'(MOTORS - 1);

  // Latched command
  cmd_t             cmd;
  logic [ARG_W-1:0] arg;

  // Per-motor state
  logic [MOTORS-1:0]  selected;
  logic [MOTORS-1:0]  running;
  logic [MOTORS-1:0]  braking;
  logic [MOTORS-1:0]  direction;
  logic [MOTORS-1:0]  pin_a_lv;
  logic [MOTORS-1:0]  pin_b_lv;
  logic [POWER_W-1:0] power [MOTORS];
  logic [DUTY_W-1:0]  duty_lv [MOTORS];

  logic [IW-1:0]      m;
  logic               flag;
  logic               sel_next;
  logic               run_next;
  logic               brk_next;
  logic               dir_next;
  logic [POWER_W-1:0] pwr_next;
  logic               pa_next;
  logic               pb_next;
  logic [DUTY_W-1:0]  duty_next;
  logic               drv_next;

  assign m    = dp_ctrl.motor[IW-1:0];
  assign flag = (arg != '0);

  // Update the current motor and rewrite its outputs when driven
  always_comb begin
    sel_next  = selected[m];
    run_next  = running[m];
    brk_next  = braking[m];
    dir_next  = direction[m];
    pwr_next  = power[m];
    pa_next   = pin_a_lv[m];
    pb_next   = pin_b_lv[m];
    duty_next = duty_lv[m];
    drv_next  = 1'b0;
    if (cmd == CMD_SELECT) begin
      sel_next = arg[dp_ctrl.motor];
    end else if (selected[m] && (cmd == CMD_ON || cmd == CMD_BRAKE ||
                 cmd == CMD_DIRECTION || cmd == CMD_REVERSE || cmd == CMD_POWER)) begin
      drv_next = 1'b1;
      unique case (cmd)
        CMD_ON: begin
          run_next = flag;
          if (flag) begin
            brk_next = 1'b0;
          end
        end
        CMD_BRAKE: begin
          brk_next = flag;
          if (flag) begin
            run_next = 1'b0;
          end
        end
        CMD_DIRECTION: begin
          dir_next = flag;
        end
        CMD_REVERSE: begin
          dir_next = !direction[m];
        end
        default: begin
          pwr_next = (arg > POWER_MAX) ? POWER_MAX[POWER_W-1:0] : arg[POWER_W-1:0];
        end
      endcase
      if (!run_next) begin
        pa_next = 1'b0;
        pb_next = 1'b0;
      end else if (brk_next) begin
        pa_next = 1'b1;
        pb_next = 1'b1;
      end else begin
        pa_next   = !dir_next;
        pb_next   = dir_next;
        duty_next = duty_of(pwr_next);
      end
    end
  end

  // Hold motor state; write back the current motor on each step
  always_ff @(posedge clk) begin
    if (rst) begin
      selected  <= '0;
      running   <= '0;
      braking   <= '0;
      direction <= '0;
      pin_a_lv  <= '0;
      pin_b_lv  <= '0;
      for (int i = 0; i < MOTORS; i++) begin
        power[i]   <= '0;
        duty_lv[i] <= DUTY_RESET;
      end
    end else if (dp_ctrl.step) begin
      selected[m]  <= sel_next;
      running[m]   <= run_next;
      braking[m]   <= brk_next;
      direction[m] <= dir_next;
      pin_a_lv[m]  <= pa_next;
      pin_b_lv[m]  <= pb_next;
      power[m]     <= pwr_next;
      duty_lv[m]   <= duty_next;
    end
  end

  // Capture the command and fill the output register
  always_ff @(posedge clk) begin
    if (dp_ctrl.load) begin
      cmd <= cmd_t'(cmd_in);
      arg <= arg_in;
    end
    if (dp_ctrl.step) begin
      motor_index <= dp_ctrl.motor;
      pin_a       <= pa_next;
      pin_b       <= pb_next;
      duty        <= duty_next;
      driven      <= drv_next;
      last        <= (dp_ctrl.motor == LAST_MOTOR);
    end
  end

endmodule

`default_nettype wire

/* sv/hbridge_motor_command_unit.sv */
// H-bridge motor command unit: one command in, one result per motor out.
// The result for motor 0 is registered at the first sequencer step after the command
// is accepted, once the output is free; the rest follow one per cycle while the
// output is taken. A new command is accepted only after the last result is registered.
// Reset (synchronous): all motors deselected, off, pins low, power 0, duty 128;
// no result pending.
`timescale 1ns / 1ps
`default_nettype none
`include "hbridge_motor_command_unit_defines.svh"

module hbridge_motor_command_unit
  import hmcu_pkg::*;
#(
  parameter int MOTORS = MOTORS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] arg
  input  logic [2:0]  s_tuser,   // [2:0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [2:0] motor_index, [3] pin_a, [4] pin_b, [12:5] duty, zero pad
  output logic        m_tuser,   // [0] driven
  output logic        m_tlast    // last
);

  dp_ctrl_t           dp_ctrl;
  logic [MOTOR_W-1:0] motor_index;
  logic               pin_a;
  logic               pin_b;
  logic [DUTY_W-1:0]  duty;

  hmcu_ctrl #(
    .MOTORS (MOTORS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .dp_ctrl  (dp_ctrl)
  );

  hmcu_datapath #(
    .MOTORS (MOTORS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .dp_ctrl     (dp_ctrl),
    .cmd_in      (s_tuser),
    .arg_in      (s_tdata),
    .motor_index (motor_index),
    .pin_a       (pin_a),
    .pin_b       (pin_b),
    .duty        (duty),
    .driven      (m_tuser),
    .last        (m_tlast)
  );

  // Pack the result fields
  assign m_tdata = {3'b000, duty, pin_b, pin_a, motor_index};

  // A command transaction blocks further commands until its last result is registered
  `HMCU_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  // While idle, any result still waiting is the last one of its command
  `HMCU_ASSERT_SAME(a_idle_pending_last, s_tready && m_tvalid, m_tlast)
  // A taken result that is not the last is replaced at once by the next motor
  `HMCU_ASSERT_NEXT(a_results_continuous, m_tvalid && m_tready && !m_tlast, m_tvalid)

endmodule

`default_nettype wire
